// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the packet-to-motor-command RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pkt2mc_pkg.sv =====
// ---------------------------------------------------------------------------
// pkt2mc_pkg
// Types and constants shared by the packet-to-motor-command modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkt2mc_pkg;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 4;

    localparam logic [15:0] SAFETY_PERIOD_RST = 16'd350;

    localparam logic [7:0] SOF_BYTE = 8'h01;
    localparam logic [7:0] ID_DRIVE = 8'hD7;
    localparam logic [7:0] ID_STOP  = 8'hE0;

    localparam logic [1:0] CAUSE_DRIVE = 2'd0;
    localparam logic [1:0] CAUSE_STOP  = 2'd1;
    localparam logic [1:0] CAUSE_WDOG  = 2'd2;

    typedef enum logic [1:0] {
        CMD_DRIVE,
        CMD_STOP,
        CMD_WDOG
    } t_cmd_kind;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] motor_byte;
        logic [1:0] cause;
        logic       last;
    } t_res;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] drive;
        logic [7:0] steer;
    } t_cmd;

endpackage

// ===== rtl/pkt2mc_fifo.sv =====
// ---------------------------------------------------------------------------
// pkt2mc_fifo
// Small synchronous FIFO with first-word fall-through read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkt2mc_fifo import pkt2mc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL, "fifo count overflow")
    `ASSERT_NEXT(a_count_inc, i_clk, i_rst_n, wr_en && !rd_en, r_count == $past(r_count) + 1'b1, "fifo count did not increment")
    `ASSERT_NEXT(a_count_dec, i_clk, i_rst_n, rd_en && !wr_en, r_count == $past(r_count) - 1'b1, "fifo count did not decrement")

endmodule

// ===== rtl/pkt2mc_front.sv =====
// ---------------------------------------------------------------------------
// pkt2mc_front
// Frame deframer and watchdog; turns accepted items into motor commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkt2mc_front import pkt2mc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_accept,
    input  t_req        i_req,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    localparam logic [4:0] POS_START = 5'd0;
    localparam logic [4:0] POS_ID    = 5'd1;
    localparam logic [4:0] POS_ACK   = 5'd6;
    localparam logic [4:0] POS_DRIVE = 5'd8;
    localparam logic [4:0] POS_STEER = 5'd9;
    localparam logic [4:0] POS_LAST  = 5'd16;

    logic [15:0] r_period;
    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_drive, n_drive;
    logic [7:0]  r_steer, n_steer;
    logic        r_ack, n_ack;
    logic        r_latched, n_latched;
    logic [15:0] r_elapsed, n_elapsed;
    logic [4:0]  pos_eff;
    logic [7:0]  rx;

    assign pos_eff = (r_pos > POS_LAST) ? POS_START : r_pos;
    assign rx      = i_req.rx_byte;

    always_comb begin
        n_pos       = r_pos;
        n_id        = r_id;
        n_drive     = r_drive;
        n_steer     = r_steer;
        n_ack       = r_ack;
        n_latched   = r_latched;
        n_elapsed   = r_elapsed;
        o_cmd_push  = 1'b0;
        o_cmd.kind  = CMD_STOP;
        o_cmd.drive = r_drive;
        o_cmd.steer = r_steer;
        if (i_accept) begin
            if (i_req.req_type) begin
                if (r_elapsed >= r_period) begin
                    n_elapsed = '0;
                    if (r_ack) begin
                        n_latched = 1'b0;
                    end else if (!r_latched) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = CMD_WDOG;
                        n_latched  = 1'b1;
                    end
                    n_ack = 1'b0;
                end else begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end else begin
                n_pos = pos_eff + 5'd1;
                unique case (pos_eff)
                    POS_START: begin
                        n_pos = (rx == SOF_BYTE) ? POS_ID : POS_START;
                    end
                    POS_ID: begin
                        n_id = rx;
                    end
                    POS_ACK: begin
                        if (rx > 8'd1) begin
                            n_pos = POS_START;
                        end else begin
                            n_ack = rx[0];
                        end
                    end
                    POS_DRIVE: begin
                        n_drive = rx;
                    end
                    POS_STEER: begin
                        n_steer = rx;
                    end
                    POS_LAST: begin
                        n_pos = POS_START;
                        if (r_id == ID_STOP) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_STOP;
                        end else if (r_id == ID_DRIVE) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_DRIVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= SAFETY_PERIOD_RST;
            r_pos     <= POS_START;
            r_id      <= '0;
            r_drive   <= '0;
            r_steer   <= '0;
            r_ack     <= 1'b0;
            r_latched <= 1'b0;
            r_elapsed <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            r_pos     <= n_pos;
            r_id      <= n_id;
            r_drive   <= n_drive;
            r_steer   <= n_steer;
            r_ack     <= n_ack;
            r_latched <= n_latched;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

// ===== rtl/pkt2mc_back.sv =====
// ---------------------------------------------------------------------------
// pkt2mc_back
// Command executor: drive-mix arithmetic pipeline and result emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkt2mc_back import pkt2mc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);

    // reciprocals: ceil(2^21/125) and ceil(2^24/1000), exact over the input ranges
    localparam logic [14:0] RECIP_125  = 15'd16778;
    localparam logic [14:0] RECIP_1000 = 15'd16778;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [13:0] nc;
        logic [13:0] t_abs;
        logic        t_neg;
    } t_s1;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [6:0] c;
        logic [3:0] o_mag;
        logic       o_neg;
    } t_s2;

    logic        r_s1_v;
    t_s1         r_s1, n_s1;
    logic        r_s2_v;
    t_s2         r_s2, n_s2;
    logic        r_phase;
    logic        s2_done;
    logic        s2_free;
    logic        s1_free;
    logic [14:0] steer_prod;
    logic [28:0] c_prod;
    logic [28:0] o_prod;
    logic [7:0]  o_val;
    logic [7:0]  m1;
    logic [7:0]  m2;

    assign s2_done    = o_res_push && (r_s2.kind != CMD_DRIVE || r_phase);
    assign s2_free    = !r_s2_v || s2_done;
    assign s1_free    = !r_s1_v || s2_free;
    assign o_cmd_pop  = s1_free && !i_cmd_empty;
    assign o_res_push = r_s2_v && !i_res_full;

    assign steer_prod = {7'd0, i_cmd.steer} * 15'd117;

    always_comb begin
        n_s1.kind = i_cmd.kind;
        n_s1.nc   = {6'd0, i_cmd.drive} * 14'd47 + 14'd124;
        if (steer_prod >= 15'd15000) begin
            n_s1.t_abs = 14'(steer_prod - 15'd15000);
            n_s1.t_neg = 1'b0;
        end else begin
            n_s1.t_abs = 14'(15'd15000 - steer_prod);
            n_s1.t_neg = 1'b1;
        end
    end

    assign c_prod = {15'd0, r_s1.nc} * {14'd0, RECIP_125};
    assign o_prod = {15'd0, r_s1.t_abs} * {14'd0, RECIP_1000};

    always_comb begin
        n_s2.kind  = r_s1.kind;
        n_s2.c     = c_prod[27:21];
        n_s2.o_mag = o_prod[27:24];
        n_s2.o_neg = r_s1.t_neg;
    end

    assign o_val = r_s2.o_neg ? (8'd0 - {4'd0, r_s2.o_mag}) : {4'd0, r_s2.o_mag};
    assign m1    = 8'd112 - {1'b0, r_s2.c} + o_val;
    assign m2    = 8'd240 - {1'b0, r_s2.c} - o_val;

    always_comb begin
        o_res.motor_byte = 8'd0;
        o_res.cause      = CAUSE_STOP;
        o_res.last       = 1'b1;
        unique case (r_s2.kind)
            CMD_DRIVE: begin
                o_res.motor_byte = r_phase ? m2 : m1;
                o_res.cause      = CAUSE_DRIVE;
                o_res.last       = r_phase;
            end
            CMD_WDOG: begin
                o_res.cause = CAUSE_WDOG;
            end
            default: begin
                o_res.cause = CAUSE_STOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= o_cmd_pop;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (s2_done) begin
                r_phase <= 1'b0;
            end else if (o_res_push) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1 <= n_s1;
        end
        if (s2_free) begin
            r_s2 <= n_s2;
        end
    end

    `ASSERT_NOW(a_phase_drive, i_clk, i_rst_n, r_phase, r_s2_v && r_s2.kind == CMD_DRIVE, "second result phase outside a drive command")
    `ASSERT_NOW(a_first_of_two, i_clk, i_rst_n, o_res_push && !o_res.last, r_s2.kind == CMD_DRIVE && !r_phase, "non-final result outside first drive byte")
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n, s2_done && !r_s1_v, !r_s2_v, "result stage not released after final transfer")

endmodule

// ===== rtl/packet_to_motor_command.sv =====
// ---------------------------------------------------------------------------
// packet_to_motor_command
// Deframes link packets into motor bytes, with a millisecond stop watchdog.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_req and raise push; the transfer happens on a clock
//   edge with push high and full low. An item is a link byte or a 1 ms tick.
//   Result queue: while empty is low, o_res holds the oldest result; raise pop
//   to take it. A drive packet gives two results (last low, then last high);
//   a stop packet or a watchdog stop gives one; other items give none.
//   Config: i_cfg_we with i_cfg_wdata writes the watchdog period; write it
//   only while the block is idle.
//   Path: a result passes the command queue, stages s1 and s2, and the result queue.
//   Throughput: one item per cycle while full is low; a drive packet holds
//   the emit stage for both its bytes; the result queue takes one per cycle.
//   Stall: when pop stays low the result queue fills, the execute pipeline
//   and command queue back up, and full rises; nothing is lost.
//   Reset (synchronous, active low): queues empty, frame awaits a start byte,
//   watchdog state clear, period back to 350 ticks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_to_motor_command import pkt2mc_pkg::*; #(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  t_req        i_req,
    output logic        empty,
    input  logic        pop,
    output t_res        o_res
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    t_cmd cmd_out;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    logic res_push;
    t_res res_in;
    logic res_full;

    assign accept = push && !cmd_full;
    assign full   = cmd_full;

    pkt2mc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_req       (i_req),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    pkt2mc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    pkt2mc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    pkt2mc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_res),
        .o_empty (empty)
    );

endmodule
